// File: design/sqe_pkg.sv
`default_nettype none
package sqe_pkg;

  localparam int BATCH_QUADS_DEF = 1500;
  localparam int SLOT_W = 11;
  localparam int BATCH_W = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CAM_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAM_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAM_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STREAK_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NOMINAL_SIZE = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HPROD, OP_HDIV, OP_HSET, OP_SHR, OP_SQ, OP_ACC,
    OP_SQRT, OP_MSET, OP_UDIV, OP_UDSET, OP_UZERO, OP_DPROD, OP_PTS, OP_AB,
    OP_SHAB, OP_CP1, OP_CSET, OP_CP2, OP_CSUB, OP_SDPROD, OP_SD, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HPROD, S_HDIV, S_HWAIT, S_USHR, S_USQ, S_UACC, S_USQRT,
    S_USWAIT, S_UDIV, S_UDWAIT, S_UZERO, S_DPROD, S_PTS, S_AB, S_SHAB,
    S_CP1, S_CSET, S_CP2, S_CSUB, S_SDPROD, S_SD, S_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
    logic       pass;
  } cmd_t;

  typedef struct packed {
    logic vec_big;
    logic ab_big;
    logic acc_zero;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: design/sqe_div.sv
`default_nettype none
module sqe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient
);

  logic [32:0] rem;
  logic [32:0] dvs;
  logic [63:0] q;
  logic [4:0]  cnt;
  logic [32:0] rem_next;
  logic [63:0] q_next;

  always_comb begin
    logic [33:0] t;
    rem_next = rem;
    q_next = q;
    for (int s = 0; s < 2; s++) begin
      t = {rem_next, q_next[63]};
      q_next = {q_next[62:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        q_next[0] = 1'b1;
      end
      rem_next = t[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      q <= q_next;
    end
  end

  assign quotient = q;

endmodule
`default_nettype wire

// File: design/sqe_sqrt.sv
`default_nettype none
module sqe_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= radicand;
      res <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = res[31:0];

endmodule
`default_nettype wire

// File: design/sqe_dp.sv
`default_nettype none
module sqe_dp #(
  parameter int BATCH_QUADS = sqe_pkg::BATCH_QUADS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sqe_pkg::cmd_t               cmd,
  output sqe_pkg::status_t                 status,
  input  wire logic signed [31:0]          cam_x,
  input  wire logic signed [31:0]          cam_y,
  input  wire logic signed [31:0]          cam_z,
  input  wire logic [30:0]                 streak_length,
  input  wire logic [30:0]                 nominal_size,
  input  wire logic signed [31:0]          pos_x,
  input  wire logic signed [31:0]          pos_y,
  input  wire logic signed [31:0]          pos_z,
  input  wire logic signed [31:0]          vel_x,
  input  wire logic signed [31:0]          vel_y,
  input  wire logic signed [31:0]          vel_z,
  input  wire logic [30:0]                 half_width,
  input  wire logic [31:0]                 rgba,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic signed [31:0]               vert_x,
  output logic signed [31:0]               vert_y,
  output logic signed [31:0]               vert_z,
  output logic                             tex_u,
  output logic                             tex_v,
  output logic [31:0]                      vert_color,
  output logic [sqe_pkg::SLOT_W+1:0]       vertex_slot,
  output logic [sqe_pkg::BATCH_W-1:0]      batch_number,
  output logic                             last
);

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat34 = 32'sh7FFF_FFFF;
    else if (v < -34'sd2147483648) sat34 = 32'sh8000_0000;
    else sat34 = v[31:0];
  endfunction

  logic signed [31:0] cam [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] p [3];
  logic [30:0]        w;
  logic [31:0]        color;
  logic [30:0]        h;
  logic [61:0]        um [3];
  logic               us [3];
  logic [61:0]        prod;
  logic               psign;
  logic [63:0]        acc;
  logic [31:0]        m;
  logic [30:0]        n_mag [3];
  logic               n_neg [3];
  logic [30:0]        u_mag [3];
  logic               u_neg [3];
  logic signed [31:0] st [3];
  logic signed [31:0] en [3];
  logic signed [31:0] sd [3];
  logic [32:0]        am [3];
  logic               a_neg [3];
  logic [32:0]        bm [3];
  logic               b_neg [3];
  logic signed [63:0] cra;
  logic [sqe_pkg::SLOT_W-1:0]  quad_slot;
  logic [sqe_pkg::BATCH_W-1:0] batch_count;

  logic [1:0]         ix;
  logic [1:0]         iy;
  logic [30:0]        ma;
  logic [30:0]        mb;
  logic               msg;
  logic [61:0]        mul_p;
  logic signed [63:0] term;
  logic signed [31:0] d32;
  logic signed [63:0] csub_v;
  logic [63:0]        csub_m;
  logic signed [32:0] a_diff [3];
  logic signed [32:0] b_diff [3];
  logic signed [31:0] vtx [3];
  logic               a_big;
  logic               b_big;
  logic               div_start;
  logic [63:0]        div_dividend;
  logic [32:0]        div_divisor;
  logic               div_busy;
  logic [63:0]        div_q;
  logic               sqrt_busy;
  logic [31:0]        sqrt_root;
  logic [sqe_pkg::SLOT_W:0] slot_inc;

  assign cam[0] = cam_x;
  assign cam[1] = cam_y;
  assign cam[2] = cam_z;
  assign vel[0] = vel_x;
  assign vel[1] = vel_y;
  assign vel[2] = vel_z;

  always_comb begin
    unique case (cmd.idx)
      2'd0: begin ix = 2'd1; iy = 2'd2; end
      2'd1: begin ix = 2'd2; iy = 2'd0; end
      default: begin ix = 2'd0; iy = 2'd1; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    msg = 1'b0;
    case (cmd.op)
      sqe_pkg::OP_HPROD: begin ma = streak_length; mb = w; end
      sqe_pkg::OP_SQ: begin ma = um[cmd.idx][30:0]; mb = um[cmd.idx][30:0]; end
      sqe_pkg::OP_DPROD: begin ma = n_mag[cmd.idx]; mb = h; msg = n_neg[cmd.idx]; end
      sqe_pkg::OP_CP1: begin
        ma = {1'b0, am[ix][29:0]};
        mb = {1'b0, bm[iy][29:0]};
        msg = a_neg[ix] ^ b_neg[iy];
      end
      sqe_pkg::OP_CP2: begin
        ma = {1'b0, am[iy][29:0]};
        mb = {1'b0, bm[ix][29:0]};
        msg = a_neg[iy] ^ b_neg[ix];
      end
      sqe_pkg::OP_SDPROD: begin ma = u_mag[cmd.idx]; mb = w; msg = u_neg[cmd.idx]; end
      default: begin end
    endcase
  end

  assign mul_p = {31'b0, ma} * {31'b0, mb};

  assign term = psign ? -$signed({2'b0, prod}) : $signed({2'b0, prod});
  assign d32 = psign ? -$signed({1'b0, prod[60:30]}) : $signed({1'b0, prod[60:30]});
  assign csub_v = cra - term;
  assign csub_m = csub_v[63] ? -csub_v : csub_v;

  always_comb begin
    logic signed [33:0] base;
    logic signed [33:0] off;
    a_big = 1'b0;
    b_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a_diff[i] = {cam[i][31], cam[i]} - {st[i][31], st[i]};
      b_diff[i] = {en[i][31], en[i]} - {st[i][31], st[i]};
      a_big = a_big | (|am[i][32:30]);
      b_big = b_big | (|bm[i][32:30]);
      base = cmd.idx[1] ? {{2{en[i][31]}}, en[i]} : {{2{st[i][31]}}, st[i]};
      off = {{2{sd[i][31]}}, sd[i]};
      vtx[i] = sat34(cmd.idx[0] ? base + off : base - off);
    end
  end

  assign div_start = (cmd.op == sqe_pkg::OP_HDIV) || (cmd.op == sqe_pkg::OP_UDIV);
  assign div_dividend = (cmd.op == sqe_pkg::OP_HDIV) ? {2'b0, prod}
                                                     : {3'b0, um[cmd.idx][30:0], 30'b0};
  assign div_divisor = (cmd.op == sqe_pkg::OP_HDIV)
                       ? {2'b0, (nominal_size == '0) ? 31'd1 : nominal_size}
                       : {1'b0, m};

  sqe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  sqe_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == sqe_pkg::OP_SQRT),
    .radicand (acc),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  assign status.vec_big = (|um[0][61:31]) | (|um[1][61:31]) | (|um[2][61:31]);
  assign status.ab_big = a_big | b_big;
  assign status.acc_zero = (acc == '0);
  assign status.div_busy = div_busy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.out_free = !out_valid || out_ready;

  assign slot_inc = {1'b0, quad_slot} + {{sqe_pkg::SLOT_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    case (cmd.op)
      sqe_pkg::OP_LOAD: begin
        p[0] <= pos_x;
        p[1] <= pos_y;
        p[2] <= pos_z;
        w <= half_width;
        color <= rgba;
        for (int i = 0; i < 3; i++) begin
          um[i] <= {30'b0, mag32(vel[i])};
          us[i] <= vel[i][31];
        end
      end
      sqe_pkg::OP_HPROD, sqe_pkg::OP_SQ, sqe_pkg::OP_DPROD, sqe_pkg::OP_CP1,
      sqe_pkg::OP_CP2, sqe_pkg::OP_SDPROD: begin
        prod <= mul_p;
        psign <= msg;
      end
      sqe_pkg::OP_HSET: h <= (|div_q[63:31]) ? 31'h7FFF_FFFF : div_q[30:0];
      sqe_pkg::OP_SHR: begin
        if (status.vec_big) begin
          for (int i = 0; i < 3; i++) um[i] <= um[i] >> 1;
        end
      end
      sqe_pkg::OP_ACC: acc <= ((cmd.idx == 2'd0) ? 64'd0 : acc) + {2'b0, prod};
      sqe_pkg::OP_MSET: m <= sqrt_root;
      sqe_pkg::OP_UDSET: begin
        if (cmd.pass) begin
          u_mag[cmd.idx] <= div_q[30:0];
          u_neg[cmd.idx] <= us[cmd.idx];
        end else begin
          n_mag[cmd.idx] <= div_q[30:0];
          n_neg[cmd.idx] <= us[cmd.idx];
        end
      end
      sqe_pkg::OP_UZERO: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd.pass) begin
            u_mag[i] <= '0;
            u_neg[i] <= 1'b0;
          end else begin
            n_mag[i] <= '0;
            n_neg[i] <= 1'b0;
          end
        end
      end
      sqe_pkg::OP_PTS: begin
        st[cmd.idx] <= sat34({{2{p[cmd.idx][31]}}, p[cmd.idx]} - {{2{d32[31]}}, d32});
        en[cmd.idx] <= sat34({{2{p[cmd.idx][31]}}, p[cmd.idx]} + {{2{d32[31]}}, d32});
      end
      sqe_pkg::OP_AB: begin
        for (int i = 0; i < 3; i++) begin
          am[i] <= a_diff[i][32] ? -a_diff[i] : a_diff[i];
          a_neg[i] <= a_diff[i][32];
          bm[i] <= b_diff[i][32] ? -b_diff[i] : b_diff[i];
          b_neg[i] <= b_diff[i][32];
        end
      end
      sqe_pkg::OP_SHAB: begin
        for (int i = 0; i < 3; i++) begin
          if (a_big) am[i] <= am[i] >> 1;
          if (b_big) bm[i] <= bm[i] >> 1;
        end
      end
      sqe_pkg::OP_CSET: cra <= term;
      sqe_pkg::OP_CSUB: begin
        um[cmd.idx] <= csub_m[61:0];
        us[cmd.idx] <= csub_v[63];
      end
      sqe_pkg::OP_SD: sd[cmd.idx] <= d32;
      sqe_pkg::OP_EMIT: begin
        vert_x <= vtx[0];
        vert_y <= vtx[1];
        vert_z <= vtx[2];
        tex_u <= cmd.idx[0];
        tex_v <= !cmd.idx[1];
        vert_color <= color;
        vertex_slot <= {quad_slot, cmd.idx};
        batch_number <= batch_count;
        last <= (cmd.idx == 2'd3);
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      quad_slot <= '0;
      batch_count <= '0;
    end else begin
      if (cmd.op == sqe_pkg::OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.op == sqe_pkg::OP_EMIT && cmd.idx == 2'd3) begin
        if (slot_inc >= (sqe_pkg::SLOT_W+1)'(BATCH_QUADS)) begin
          quad_slot <= '0;
          batch_count <= batch_count + {{(sqe_pkg::BATCH_W-1){1'b0}}, 1'b1};
        end else begin
          quad_slot <= slot_inc[sqe_pkg::SLOT_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: design/sqe_ctrl.sv
`default_nettype none
module sqe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sqe_pkg::status_t status,
  output sqe_pkg::cmd_t         cmd
);

  sqe_pkg::state_t state, state_next;
  logic [1:0] idx, idx_next;
  logic       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqe_pkg::S_IDLE;
      idx <= '0;
      pass <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      pass <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    pass_next = pass;
    in_ready = 1'b0;
    cmd.op = sqe_pkg::OP_NONE;
    cmd.idx = idx;
    cmd.pass = pass;
    unique case (state)
      sqe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = sqe_pkg::OP_LOAD;
          pass_next = 1'b0;
          state_next = sqe_pkg::S_HPROD;
        end
      end
      sqe_pkg::S_HPROD: begin
        cmd.op = sqe_pkg::OP_HPROD;
        state_next = sqe_pkg::S_HDIV;
      end
      sqe_pkg::S_HDIV: begin
        cmd.op = sqe_pkg::OP_HDIV;
        state_next = sqe_pkg::S_HWAIT;
      end
      sqe_pkg::S_HWAIT: begin
        if (!status.div_busy) begin
          cmd.op = sqe_pkg::OP_HSET;
          state_next = sqe_pkg::S_USHR;
        end
      end
      sqe_pkg::S_USHR: begin
        cmd.op = sqe_pkg::OP_SHR;
        if (!status.vec_big) begin
          idx_next = 2'd0;
          state_next = sqe_pkg::S_USQ;
        end
      end
      sqe_pkg::S_USQ: begin
        cmd.op = sqe_pkg::OP_SQ;
        state_next = sqe_pkg::S_UACC;
      end
      sqe_pkg::S_UACC: begin
        cmd.op = sqe_pkg::OP_ACC;
        if (idx == 2'd2) begin
          idx_next = 2'd0;
          state_next = sqe_pkg::S_USQRT;
        end else begin
          idx_next = idx + 2'd1;
          state_next = sqe_pkg::S_USQ;
        end
      end
      sqe_pkg::S_USQRT: begin
        if (status.acc_zero) begin
          state_next = sqe_pkg::S_UZERO;
        end else begin
          cmd.op = sqe_pkg::OP_SQRT;
          state_next = sqe_pkg::S_USWAIT;
        end
      end
      sqe_pkg::S_USWAIT: begin
        if (!status.sqrt_busy) begin
          cmd.op = sqe_pkg::OP_MSET;
          idx_next = 2'd0;
          state_next = sqe_pkg::S_UDIV;
        end
      end
      sqe_pkg::S_UDIV: begin
        cmd.op = sqe_pkg::OP_UDIV;
        state_next = sqe_pkg::S_UDWAIT;
      end
      sqe_pkg::S_UDWAIT: begin
        if (!status.div_busy) begin
          cmd.op = sqe_pkg::OP_UDSET;
          if (idx == 2'd2) begin
            idx_next = 2'd0;
            state_next = pass ? sqe_pkg::S_SDPROD : sqe_pkg::S_DPROD;
          end else begin
            idx_next = idx + 2'd1;
            state_next = sqe_pkg::S_UDIV;
          end
        end
      end
      sqe_pkg::S_UZERO: begin
        cmd.op = sqe_pkg::OP_UZERO;
        idx_next = 2'd0;
        state_next = pass ? sqe_pkg::S_SDPROD : sqe_pkg::S_DPROD;
      end
      sqe_pkg::S_DPROD: begin
        cmd.op = sqe_pkg::OP_DPROD;
        state_next = sqe_pkg::S_PTS;
      end
      sqe_pkg::S_PTS: begin
        cmd.op = sqe_pkg::OP_PTS;
        if (idx == 2'd2) begin
          idx_next = 2'd0;
          state_next = sqe_pkg::S_AB;
        end else begin
          idx_next = idx + 2'd1;
          state_next = sqe_pkg::S_DPROD;
        end
      end
      sqe_pkg::S_AB: begin
        cmd.op = sqe_pkg::OP_AB;
        state_next = sqe_pkg::S_SHAB;
      end
      sqe_pkg::S_SHAB: begin
        cmd.op = sqe_pkg::OP_SHAB;
        if (!status.ab_big) begin
          idx_next = 2'd0;
          state_next = sqe_pkg::S_CP1;
        end
      end
      sqe_pkg::S_CP1: begin
        cmd.op = sqe_pkg::OP_CP1;
        state_next = sqe_pkg::S_CSET;
      end
      sqe_pkg::S_CSET: begin
        cmd.op = sqe_pkg::OP_CSET;
        state_next = sqe_pkg::S_CP2;
      end
      sqe_pkg::S_CP2: begin
        cmd.op = sqe_pkg::OP_CP2;
        state_next = sqe_pkg::S_CSUB;
      end
      sqe_pkg::S_CSUB: begin
        cmd.op = sqe_pkg::OP_CSUB;
        if (idx == 2'd2) begin
          idx_next = 2'd0;
          pass_next = 1'b1;
          state_next = sqe_pkg::S_USHR;
        end else begin
          idx_next = idx + 2'd1;
          state_next = sqe_pkg::S_CP1;
        end
      end
      sqe_pkg::S_SDPROD: begin
        cmd.op = sqe_pkg::OP_SDPROD;
        state_next = sqe_pkg::S_SD;
      end
      sqe_pkg::S_SD: begin
        cmd.op = sqe_pkg::OP_SD;
        if (idx == 2'd2) begin
          idx_next = 2'd0;
          state_next = sqe_pkg::S_EMIT;
        end else begin
          idx_next = idx + 2'd1;
          state_next = sqe_pkg::S_SDPROD;
        end
      end
      sqe_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.op = sqe_pkg::OP_EMIT;
          if (idx == 2'd3) begin
            idx_next = 2'd0;
            state_next = sqe_pkg::S_IDLE;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      default: state_next = sqe_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/streak_quad_expander.sv
// Streak quad expander: turns one particle request into the four vertices of a
// camera-facing streak quad.
// The slave stream carries one particle per request; the master stream carries
// the four vertices in order start-side, start+side, end-side, end+side, with
// tlast on the fourth. The camera position, streak length and nominal size are
// written through the APB port; the user must write them only while the block
// is idle, which the block itself does not enforce. One particle is worked on
// at a time. The time from acceptance to its first vertex is set mostly by the
// shared iterative divider (used for the half length and six unit vector
// components) and the square root unit (used twice). The time varies with the
// normalizing shifts of the velocity, the cross product inputs and the cross
// product. A zero velocity or a degenerate cross product skips that square
// root and its three divisions. Without stalls the four vertices leave on
// consecutive cycles and the sequencer is ready for the next particle in the
// cycle after the last vertex enters the output register.
// A stalled receiver holds the output register and stops the sequencer before
// the next vertex; no data is dropped.
// Reset returns the sequencer to idle, empties the output register, clears the
// slot and batch counters and restores the register defaults.
`default_nettype none
module streak_quad_expander #(
  parameter int BATCH_QUADS = sqe_pkg::BATCH_QUADS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, half_width, rgba, zero pad
  input  wire logic [255:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // vert_x, vert_y, vert_z, tex_u, tex_v, vert_color, vertex_slot,
  // batch_number, zero pad
  output logic [151:0]      m_tdata,
  output logic              m_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic [30:0]        streak_length;
  logic [30:0]        nominal_size;
  sqe_pkg::cmd_t      cmd;
  sqe_pkg::status_t   status;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic               tex_u;
  logic               tex_v;
  logic [31:0]        vert_color;
  logic [sqe_pkg::SLOT_W+1:0]  vertex_slot;
  logic [sqe_pkg::BATCH_W-1:0] batch_number;
  logic [sqe_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      streak_length <= 31'd65536;
      nominal_size <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        sqe_pkg::REG_CAM_X: cam_x <= pwdata;
        sqe_pkg::REG_CAM_Y: cam_y <= pwdata;
        sqe_pkg::REG_CAM_Z: cam_z <= pwdata;
        sqe_pkg::REG_STREAK_LENGTH: streak_length <= pwdata[30:0];
        sqe_pkg::REG_NOMINAL_SIZE: nominal_size <= pwdata[30:0];
        default: begin end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sqe_pkg::REG_CAM_X: prdata = cam_x;
      sqe_pkg::REG_CAM_Y: prdata = cam_y;
      sqe_pkg::REG_CAM_Z: prdata = cam_z;
      sqe_pkg::REG_STREAK_LENGTH: prdata = {1'b0, streak_length};
      sqe_pkg::REG_NOMINAL_SIZE: prdata = {1'b0, nominal_size};
      default: prdata = '0;
    endcase
  end

  sqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sqe_dp #(
    .BATCH_QUADS (BATCH_QUADS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cam_x         (cam_x),
    .cam_y         (cam_y),
    .cam_z         (cam_z),
    .streak_length (streak_length),
    .nominal_size  (nominal_size),
    .pos_x         (s_tdata[31:0]),
    .pos_y         (s_tdata[63:32]),
    .pos_z         (s_tdata[95:64]),
    .vel_x         (s_tdata[127:96]),
    .vel_y         (s_tdata[159:128]),
    .vel_z         (s_tdata[191:160]),
    .half_width    (s_tdata[222:192]),
    .rgba          (s_tdata[254:223]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .vert_x        (vert_x),
    .vert_y        (vert_y),
    .vert_z        (vert_z),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .vert_color    (vert_color),
    .vertex_slot   (vertex_slot),
    .batch_number  (batch_number),
    .last          (m_tlast)
  );

  assign m_tdata = {1'b0, batch_number, vertex_slot, vert_color, tex_v, tex_u,
                    vert_z, vert_y, vert_x};

endmodule
`default_nettype wire

// File: design/sqe_checker.sv
`default_nettype none
module sqe_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic m_tlast
);

  a_reset_idle: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("vertex dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second particle taken while one is in work");

  a_gap_after_quad: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("vertex appeared right after the end of a quad");

endmodule

bind streak_quad_expander sqe_checker u_sqe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// File: dv/streak_quad_expander_tb.sv
`timescale 1ns / 1ps
module streak_quad_expander_tb;

  typedef struct {
    logic [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [30:0] half_width;
    logic [31:0] rgba;
  } particle_t;

  typedef struct {
    logic [31:0] vert_x, vert_y, vert_z;
    logic        tex_u, tex_v;
    logic [31:0] vert_color;
    logic [12:0] vertex_slot;
    logic [7:0]  batch_number;
    logic        last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [255:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [151:0] m_tdata;
  logic m_tlast;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  streak_quad_expander uut (.*);

  particle_t pending_particles[$];
  vertex_t expected_vertices[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  longint cam_pos[3];
  logic [30:0] streak_len, nom_size;
  logic [10:0] quad_slot;
  logic [7:0] batch_count;

  initial forever #2 clk = ~clk;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    logic [63:0] p;
    p = (mag(a) * mag(b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void shrink_vec(inout longint v[3], input int bits);
    logic [63:0] m;
    int s;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
    while (s < 63 && (m >> s) >= (64'd1 << bits)) s++;
    for (int i = 0; i < 3; i++)
      v[i] = v[i] < 0 ? -longint'(mag(v[i]) >> s) : longint'(mag(v[i]) >> s);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void normalize(input longint c[3], output longint u[3]);
    longint w[3];
    logic [63:0] sum, m;
    w = c;
    sum = 0;
    shrink_vec(w, 31);
    for (int i = 0; i < 3; i++) sum += mag(w[i]) * mag(w[i]);
    if (sum == 0) begin
      u = '{0, 0, 0};
      return;
    end
    m = int_sqrt(sum);
    for (int i = 0; i < 3; i++)
      u[i] = w[i] < 0 ? -longint'((mag(w[i]) << 30) / m)
                      : longint'((mag(w[i]) << 30) / m);
  endfunction

  function automatic void expand_particle(particle_t pt);
    longint p[3], v[3], n[3], st[3], en[3], a[3], b[3], cr[3], u[3], sd[3], d;
    longint vx[4][3];
    logic [63:0] h, dv;
    vertex_t vt;
    dv = nom_size != 0 ? nom_size : 1;
    h = (64'(streak_len) * 64'(pt.half_width)) / dv;
    if (h > 64'h7FFFFFFF) h = 64'h7FFFFFFF;
    p = '{longint'(signed'(pt.pos_x)), longint'(signed'(pt.pos_y)),
          longint'(signed'(pt.pos_z))};
    v = '{longint'(signed'(pt.vel_x)), longint'(signed'(pt.vel_y)),
          longint'(signed'(pt.vel_z))};
    normalize(v, n);
    for (int i = 0; i < 3; i++) begin
      d = mul_q30(n[i], longint'(h));
      st[i] = sat32(p[i] - d);
      en[i] = sat32(p[i] + d);
      a[i] = cam_pos[i] - st[i];
      b[i] = en[i] - st[i];
    end
    shrink_vec(a, 30);
    shrink_vec(b, 30);
    cr[0] = a[1] * b[2] - a[2] * b[1];
    cr[1] = a[2] * b[0] - a[0] * b[2];
    cr[2] = a[0] * b[1] - a[1] * b[0];
    normalize(cr, u);
    for (int i = 0; i < 3; i++) begin
      sd[i] = mul_q30(u[i], longint'(pt.half_width));
      vx[0][i] = sat32(st[i] - sd[i]);
      vx[1][i] = sat32(st[i] + sd[i]);
      vx[2][i] = sat32(en[i] - sd[i]);
      vx[3][i] = sat32(en[i] + sd[i]);
    end
    for (int k = 0; k < 4; k++) begin
      vt.vert_x = vx[k][0][31:0];
      vt.vert_y = vx[k][1][31:0];
      vt.vert_z = vx[k][2][31:0];
      vt.tex_u = k[0];
      vt.tex_v = k < 2;
      vt.vert_color = pt.rgba;
      vt.vertex_slot = 13'(quad_slot * 4 + k);
      vt.batch_number = batch_count;
      vt.last = k == 3;
      expected_vertices.push_back(vt);
    end
    if (quad_slot + 1 >= sqe_pkg::BATCH_QUADS_DEF) begin
      quad_slot = 0;
      batch_count++;
    end else begin
      quad_slot++;
    end
  endfunction

  always @(posedge clk) begin
    particle_t pt;
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_particles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pt = pending_particles.pop_front();
        s_tvalid <= 1;
        s_tdata <= {1'b0, pt.rgba, pt.half_width, pt.vel_z, pt.vel_y, pt.vel_x,
                    pt.pos_z, pt.pos_y, pt.pos_x};
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    particle_t pt;
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct;
      if (s_tvalid && s_tready) begin
        pt.pos_x = s_tdata[31:0];
        pt.pos_y = s_tdata[63:32];
        pt.pos_z = s_tdata[95:64];
        pt.vel_x = s_tdata[127:96];
        pt.vel_y = s_tdata[159:128];
        pt.vel_z = s_tdata[191:160];
        pt.half_width = s_tdata[222:192];
        pt.rgba = s_tdata[254:223];
        expand_particle(pt);
      end
      if (m_tvalid && m_tready) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex %h last %b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          e = expected_vertices.pop_front();
          if (m_tdata[31:0] !== e.vert_x || m_tdata[63:32] !== e.vert_y ||
              m_tdata[95:64] !== e.vert_z || m_tdata[96] !== e.tex_u ||
              m_tdata[97] !== e.tex_v || m_tdata[129:98] !== e.vert_color ||
              m_tdata[142:130] !== e.vertex_slot ||
              m_tdata[150:143] !== e.batch_number || m_tlast !== e.last) begin
            $display("%0t: expected xyz %h %h %h uv %b%b col %h slot %0d batch %0d last %b",
                     $time, e.vert_x, e.vert_y, e.vert_z, e.tex_u, e.tex_v,
                     e.vert_color, e.vertex_slot, e.batch_number, e.last);
            $display("%0t: actual   xyz %h %h %h uv %b%b col %h slot %0d batch %0d last %b",
                     $time, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[96],
                     m_tdata[97], m_tdata[129:98], m_tdata[142:130], m_tdata[150:143],
                     m_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == sqe_pkg::REG_CAM_X || idx == sqe_pkg::REG_CAM_Y ||
        idx == sqe_pkg::REG_CAM_Z)
      cam_pos[idx] = longint'(signed'(val));
    else if (idx == sqe_pkg::REG_STREAK_LENGTH) streak_len = val[30:0];
    else if (idx == sqe_pkg::REG_NOMINAL_SIZE) nom_size = val[30:0];
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return 32'($signed($urandom_range(40000000)) - 20000000);
      default: return $urandom_range(1) ? 32'h0 : 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t pt;
    pt.pos_x = rand_coord();
    pt.pos_y = rand_coord();
    pt.pos_z = rand_coord();
    pt.vel_x = rand_coord();
    pt.vel_y = rand_coord();
    pt.vel_z = rand_coord();
    pt.half_width = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(400000));
    pt.rgba = $urandom;
    return pt;
  endfunction

  function automatic particle_t make_particle(logic [31:0] px, py, pz, vx, vy, vz,
                                              logic [30:0] w, logic [31:0] c);
    particle_t pt;
    pt = '{px, py, pz, vx, vy, vz, w, c};
    return pt;
  endfunction

  task automatic drain();
    wait (pending_particles.size() == 0 && !s_tvalid && expected_vertices.size() == 0);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    cam_pos = '{0, 0, 0};
    streak_len = 31'd65536;
    nom_size = 31'd65536;
    quad_slot = 0;
    batch_count = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    pending_particles.push_back(make_particle(0, 0, 0, 0, 0, 0, 0, 0));
    pending_particles.push_back(make_particle(32'h10000, 0, 32'h50000, 0, 0, 0,
                                              31'h10000, 32'hFFFFFFFF));
    pending_particles.push_back(make_particle(0, 0, 32'h50000, 32'h10000, 0, 0,
                                              31'h8000, 32'h12345678));
    pending_particles.push_back(make_particle(0, 0, 0, 32'h10000, 0, 0, 31'h10000, 1));
    pending_particles.push_back(make_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'hA5A5A5A5));
    pending_particles.push_back(make_particle(32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 32'h5A5A5A5A));
    pending_particles.push_back(make_particle(32'h80000000, 32'h7FFFFFFF, 0,
        32'h80000000, 32'h7FFFFFFF, 1, 31'h40000000, 32'h80000001));
    pending_particles.push_back(make_particle(0, 32'h30000, 0, 0, 0, 32'hFFFF0000,
                                              31'h7FFFFFFF, 32'h0F0F0F0F));
    pending_particles.push_back(make_particle(32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 1, 1,
                                              31'd1, 32'hF0F0F0F0));
    pending_particles.push_back(make_particle(32'h12345678, 32'hEDCBA987, 32'h00C0FFEE,
        32'hFFFFFFFF, 0, 0, 31'h55555555, 32'h3C3C3C3C));
    repeat (70) pending_particles.push_back(rand_particle());
    drain();

    send_idle_pct = 82;
    write_reg(sqe_pkg::REG_CAM_X, 32'h00030000);
    write_reg(sqe_pkg::REG_CAM_Y, 32'hFFFE0000);
    write_reg(sqe_pkg::REG_CAM_Z, 32'h00100000);
    write_reg(sqe_pkg::REG_STREAK_LENGTH, 32'h7FFFFFFF);
    write_reg(sqe_pkg::REG_NOMINAL_SIZE, 32'h0);
    repeat (90) pending_particles.push_back(rand_particle());
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 82;
    write_reg(sqe_pkg::REG_CAM_X, 32'h80000000);
    write_reg(sqe_pkg::REG_CAM_Y, 32'h7FFFFFFF);
    write_reg(sqe_pkg::REG_CAM_Z, 32'h0);
    write_reg(sqe_pkg::REG_STREAK_LENGTH, 32'h0);
    write_reg(sqe_pkg::REG_NOMINAL_SIZE, 32'h7FFFFFFF);
    repeat (90) pending_particles.push_back(rand_particle());
    drain();

    send_idle_pct = 30;
    recv_stall_pct = 30;
    write_reg(sqe_pkg::REG_CAM_X, rand_coord());
    write_reg(sqe_pkg::REG_CAM_Y, rand_coord());
    write_reg(sqe_pkg::REG_CAM_Z, rand_coord());
    write_reg(sqe_pkg::REG_STREAK_LENGTH, $urandom_range(32'h80000));
    write_reg(sqe_pkg::REG_NOMINAL_SIZE, $urandom_range(1, 32'h40000));
    write_reg(5, $urandom);
    write_reg(7, $urandom);
    repeat (90) pending_particles.push_back(rand_particle());
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: filelist.f
design/sqe_pkg.sv
design/sqe_div.sv
design/sqe_sqrt.sv
design/sqe_dp.sv
design/sqe_ctrl.sv
design/streak_quad_expander.sv
design/sqe_checker.sv
dv/streak_quad_expander_tb.sv
